/* sv/lgtg_pkg.sv */
// ----------------------------------------------------------------------------
// lgtg_pkg
// Shared types and constants for the leg gait trajectory generator.
// ----------------------------------------------------------------------------
package lgtg_pkg;

   localparam int POS_W   = 20;
   localparam int OUT_W   = 21;
   localparam int TIME_W  = 32;
   localparam int CYCLE_W = 24;
   localparam int AMP_W   = 18;
   localparam int PHASE_W = 16;
   localparam int ROM_W   = 16;
   localparam int CNT_W   = 5;
   localparam int REM_W   = 26;
   localparam int PROD_W  = 34;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [1:0] CSR_STEP_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_STEP_LENGTH = 2'd1;
   localparam logic [1:0] CSR_CYCLE_TICKS = 2'd2;
   localparam logic [1:0] CSR_GAIT_MODE   = 2'd3;

   localparam logic [CYCLE_W-1:0] CYCLE_RESET = 24'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FRAC0,
      ST_FRAC1,
      ST_RD_COS,
      ST_RD_SIN,
      ST_MUL,
      ST_EMIT
   } st_type;

endpackage

/* sv/leg_gait_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// leg_gait_trajectory_generator
// Tripod or in-phase gait foot trajectory generator: neutral positions per leg, one foot
// target per leg for each step item.
// ----------------------------------------------------------------------------
// A load item (command 0) stores a leg's neutral x/y/z and gives no
// result. A step item (command 1) gives LEG_COUNT results, leg 0 first,
// last set on the final one. Until every leg is loaded the results are zero
// with not_ready set, one per cycle while the receiver takes them. Once all
// legs are loaded a step's work is set by the shared restoring divider, one
// bit per cycle, that forms the time modulo the cycle and the phase
// fractions (the second only in tripod mode), and by the single-port sine
// ROM, read twice per leg. Neutral positions live in a synchronous RAM with
// no reset; the sine ROM is built at elaboration. New items are taken only
// when the previous step has handed its last result to the output register.
module leg_gait_trajectory_generator
   import lgtg_pkg::*;
#(
   parameter int LEG_COUNT       = 6,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [2:0]               req_leg,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic [TIME_W-1:0]        req_time_req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_leg_out,
   output logic signed [OUT_W-1:0]  rsp_foot_x,
   output logic signed [OUT_W-1:0]  rsp_foot_y,
   output logic signed [OUT_W-1:0]  rsp_foot_z,
   output logic                     rsp_not_ready,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CYCLE_W-1:0]       csr_wdata
);

   localparam int LEG_W  = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam int IDX_W  = SINE_TABLE_BITS + 2;
   localparam int ADDR_W = SINE_TABLE_BITS + 1;
   localparam int ROW_W  = 3 * POS_W;

   typedef logic [ROM_W-1:0] rom_type [SINE_N+1];

   function automatic rom_type build_sine_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      for (int k = 0; k <= SINE_N; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / SINE_N;
         sum  = longint'(x);
         term = x;
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / 64'd6;
         sum  = sum - longint'(term);
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / 64'd20;
         sum  = sum + longint'(term);
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / 64'd42;
         sum  = sum - longint'(term);
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / 64'd72;
         sum  = sum + longint'(term);
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / 64'd110;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         rom[k] = ROM_W'(($unsigned(sum) + 64'd16384) >> 15);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_sine_rom();

   // quarter-wave fold: odd quadrants read the table mirrored
   function automatic logic [ADDR_W-1:0] quad_addr(input logic [IDX_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = {1'b0, v[SINE_TABLE_BITS-1:0]};
      return v[SINE_TABLE_BITS] ? ADDR_W'(SINE_N) - r : r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
      if (v[OUT_W:OUT_W-1] == 2'b01) begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end else if (v[OUT_W:OUT_W-1] == 2'b10) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end
      return v[OUT_W-1:0];
   endfunction

   // configuration
   logic [AMP_W-1:0]   step_height_ff;
   logic [AMP_W-1:0]   step_length_ff;
   logic [CYCLE_W-1:0] cycle_ff;
   logic               gait_mode_ff;

   // control
   st_type             state_ff, state_in;
   logic [LEG_COUNT-1:0] loaded_ff;
   logic [LEG_W-1:0]   leg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;

   // datapath
   logic [REM_W-1:0]   rem_ff;
   logic [TIME_W-1:0]  shreg_ff;
   logic [CYCLE_W-1:0] r_ff;
   logic [PHASE_W-1:0] phase0_ff, phase1_ff;
   logic [ROM_W-1:0]   rom_q_ff, cos_mag_ff;
   logic [PROD_W-1:0]  prod_x_ff, prod_z_ff;
   logic [ROW_W-1:0]   neutral_mem [LEG_COUNT];
   logic [ROW_W-1:0]   neutral_q_ff;

   logic [2:0]              leg_out_ff;
   logic signed [OUT_W-1:0] foot_x_ff, foot_y_ff, foot_z_ff;
   logic                    not_ready_ff, last_ff;

   // combinational
   logic               all_loaded, leg_last, leg_ok;
   logic               step_go, load_go, div_last, emit_go, mem_rd;
   logic [ADDR_W-1:0]  rom_addr;
   logic [CYCLE_W-1:0] cyc_eff;
   logic [REM_W-1:0]   dvs, trial, rem_step, num1_sum, two_c, num1;
   logic               ge;
   logic [TIME_W-1:0]  shreg_step;
   logic [PHASE_W-1:0] phase_sel;
   logic [IDX_W-1:0]   sin_idx, cos_idx;
   logic               cos_neg, sin_neg, swing;
   logic [18:0]        vx, vz;
   logic signed [OUT_W:0] sx, sz, nx, ny, nz, x_full, z_full;

   assign all_loaded = &loaded_ff;
   assign leg_last   = (leg_ff == LEG_W'(LEG_COUNT - 1));
   assign leg_ok     = ({1'b0, req_leg} < 4'(LEG_COUNT));
   assign step_go    = req_valid && req_ready && (req_command == CMD_STEP);
   assign load_go    = req_valid && req_ready && (req_command == CMD_LOAD) && leg_ok;
   assign cyc_eff    = (cycle_ff == '0) ? CYCLE_W'(1) : cycle_ff;

   // shared restoring divider, one quotient bit per cycle
   assign dvs        = (state_ff == ST_MOD) ? {2'b0, cyc_eff} : {1'b0, cyc_eff, 1'b0};
   assign trial      = {rem_ff[REM_W-2:0], (state_ff == ST_MOD) ? shreg_ff[TIME_W-1] : 1'b0};
   assign ge         = (trial >= dvs);
   assign rem_step   = ge ? trial - dvs : trial;
   assign shreg_step = {shreg_ff[TIME_W-2:0], ge};

   // numerator for the half-cycle-shifted phase
   assign two_c    = {1'b0, cyc_eff, 1'b0};
   assign num1_sum = {1'b0, r_ff, 1'b0} + {2'b0, cyc_eff};
   assign num1     = (num1_sum >= two_c) ? num1_sum - two_c : num1_sum;

   assign phase_sel = (gait_mode_ff && leg_ff[0]) ? phase1_ff : phase0_ff;
   assign sin_idx   = phase_sel[PHASE_W-1 -: IDX_W];
   assign cos_idx   = sin_idx + IDX_W'(SINE_N);
   assign cos_neg   = cos_idx[IDX_W-1];
   assign sin_neg   = sin_idx[IDX_W-1];
   assign swing     = ~phase_sel[PHASE_W-1];

   assign vx = 19'((prod_x_ff + PROD_W'(16384)) >> 15);
   assign vz = 19'((prod_z_ff + PROD_W'(16384)) >> 15);
   assign sx = cos_neg ? -$signed({3'b0, vx}) : $signed({3'b0, vx});
   assign sz = sin_neg ? -$signed({3'b0, vz}) : $signed({3'b0, vz});
   assign nx = {{2{neutral_q_ff[ROW_W-1]}}, neutral_q_ff[ROW_W-1 -: POS_W]};
   assign ny = {{2{neutral_q_ff[2*POS_W-1]}}, neutral_q_ff[2*POS_W-1 -: POS_W]};
   assign nz = {{2{neutral_q_ff[POS_W-1]}}, neutral_q_ff[POS_W-1:0]};
   assign x_full = nx - sx;
   assign z_full = swing ? nz + sz : nz;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (step_go) begin
               state_in = all_loaded ? ST_MOD : ST_EMIT;
            end
         end
         ST_MOD: begin
            if (div_last) begin
               state_in = ST_FRAC0;
            end
         end
         ST_FRAC0: begin
            if (div_last) begin
               state_in = gait_mode_ff ? ST_FRAC1 : ST_RD_COS;
            end
         end
         ST_FRAC1: begin
            if (div_last) begin
               state_in = ST_RD_COS;
            end
         end
         ST_RD_COS: state_in = ST_RD_SIN;
         ST_RD_SIN: state_in = ST_MUL;
         ST_MUL:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               if (leg_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = all_loaded ? ST_RD_COS : ST_EMIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_last  = 1'b0;
      emit_go   = 1'b0;
      mem_rd    = 1'b0;
      rom_addr  = quad_addr(sin_idx);
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_MOD:   div_last  = (cnt_ff == CNT_W'(TIME_W - 1));
         ST_FRAC0: div_last  = (cnt_ff == CNT_W'(PHASE_W - 1));
         ST_FRAC1: div_last  = (cnt_ff == CNT_W'(PHASE_W - 1));
         ST_RD_COS: begin
            mem_rd   = 1'b1;
            rom_addr = quad_addr(cos_idx);
         end
         ST_EMIT:  emit_go = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         loaded_ff      <= '0;
         leg_ff         <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         step_height_ff <= '0;
         step_length_ff <= '0;
         cycle_ff       <= CYCLE_RESET;
         gait_mode_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit_go || (rsp_valid_ff && !rsp_ready);
         if (load_go) begin
            loaded_ff <= loaded_ff | (LEG_COUNT'(1) << req_leg[LEG_W-1:0]);
         end
         if (step_go) begin
            leg_ff <= '0;
         end else if (emit_go) begin
            leg_ff <= leg_ff + LEG_W'(1);
         end
         if ((state_ff == ST_MOD || state_ff == ST_FRAC0 || state_ff == ST_FRAC1)
             && !div_last) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else begin
            cnt_ff <= '0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_STEP_HEIGHT: step_height_ff <= csr_wdata[AMP_W-1:0];
               CSR_STEP_LENGTH: step_length_ff <= csr_wdata[AMP_W-1:0];
               CSR_CYCLE_TICKS: cycle_ff       <= csr_wdata;
               CSR_GAIT_MODE:   gait_mode_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // neutral position RAM and sine ROM, registered reads
   always_ff @(posedge clock) begin
      if (load_go) begin
         neutral_mem[req_leg[LEG_W-1:0]] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      if (mem_rd) begin
         neutral_q_ff <= neutral_mem[leg_ff];
      end
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (step_go) begin
               shreg_ff <= req_time_req;
               rem_ff   <= '0;
            end
         end
         ST_MOD: begin
            shreg_ff <= shreg_step;
            if (div_last) begin
               rem_ff <= {rem_step[REM_W-2:0], 1'b0};
               r_ff   <= rem_step[CYCLE_W-1:0];
            end else begin
               rem_ff <= rem_step;
            end
         end
         ST_FRAC0: begin
            shreg_ff <= shreg_step;
            if (div_last) begin
               phase0_ff <= shreg_step[PHASE_W-1:0];
               rem_ff    <= num1;
            end else begin
               rem_ff <= rem_step;
            end
         end
         ST_FRAC1: begin
            shreg_ff <= shreg_step;
            rem_ff   <= rem_step;
            if (div_last) begin
               phase1_ff <= shreg_step[PHASE_W-1:0];
            end
         end
         ST_RD_SIN: cos_mag_ff <= rom_q_ff;
         ST_MUL: begin
            prod_x_ff <= PROD_W'(step_length_ff) * PROD_W'(cos_mag_ff);
            prod_z_ff <= PROD_W'(step_height_ff) * PROD_W'(rom_q_ff);
         end
         default: begin
         end
      endcase
      if (emit_go) begin
         leg_out_ff   <= 3'(leg_ff);
         last_ff      <= leg_last;
         not_ready_ff <= !all_loaded;
         if (all_loaded) begin
            foot_x_ff <= sat_out(x_full);
            foot_y_ff <= ny[OUT_W-1:0];
            foot_z_ff <= sat_out(z_full);
         end else begin
            foot_x_ff <= '0;
            foot_y_ff <= '0;
            foot_z_ff <= '0;
         end
      end
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_leg_out   = leg_out_ff;
   assign rsp_foot_x    = foot_x_ff;
   assign rsp_foot_y    = foot_y_ff;
   assign rsp_foot_z    = foot_z_ff;
   assign rsp_not_ready = not_ready_ff;
   assign rsp_last      = last_ff;

endmodule

/* tb/sv/leg_gait_trajectory_generator_test.sv */
// ----------------------------------------------------------------------------
// leg_gait_trajectory_generator_test
// Self-checking bench: loads neutral foot positions, sweeps the gait settings
// and step times, and checks every foot target against an in-bench model of
// the phase, quarter-wave sine table, scaling and saturation.
// ----------------------------------------------------------------------------
module leg_gait_trajectory_generator_test;
   import lgtg_pkg::*;

   localparam int     LEGS        = 6;
   localparam int     TABLE_BITS  = 10;
   localparam int     TABLE_N     = 1 << TABLE_BITS;
   localparam int     SETTLE      = 120;
   localparam int     STALL_LIMIT = 4000;
   localparam int     HOLD_LEN    = 400;
   localparam longint FOOT_MAX    = 1048575;
   localparam longint FOOT_MIN    = -1048576;

   typedef struct packed {
      logic [2:0]       leg;
      logic [OUT_W-1:0] x, y, z;
      logic             not_ready;
      logic             last;
   } foot_target_type;

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_ready;
   logic                    req_command  = CMD_LOAD;
   logic [2:0]              req_leg      = '0;
   logic signed [POS_W-1:0] req_pos_x    = '0;
   logic signed [POS_W-1:0] req_pos_y    = '0;
   logic signed [POS_W-1:0] req_pos_z    = '0;
   logic [TIME_W-1:0]       req_time_req = '0;
   logic                    rsp_valid;
   logic                    rsp_ready    = 1'b0;
   logic [2:0]              rsp_leg_out;
   logic signed [OUT_W-1:0] rsp_foot_x;
   logic signed [OUT_W-1:0] rsp_foot_y;
   logic signed [OUT_W-1:0] rsp_foot_z;
   logic                    rsp_not_ready;
   logic                    rsp_last;
   logic                    csr_valid    = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index    = '0;
   logic [CYCLE_W-1:0]      csr_wdata    = '0;

   // model state
   longint unsigned    sine_q15 [0:TABLE_N];
   longint             nrm_x [LEGS];
   longint             nrm_y [LEGS];
   longint             nrm_z [LEGS];
   logic [LEGS-1:0]    legs_loaded;
   logic [AMP_W-1:0]   lift_um;
   logic [AMP_W-1:0]   swing_um;
   logic [CYCLE_W-1:0] period_ticks;
   logic               tripod;

   foot_target_type foot_targets_due [$];
   foot_target_type due;
   int           errors        = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_go       = 0;
   int           hold_left     = 0;
   int           quiet_cycles  = 0;

   leg_gait_trajectory_generator #(
      .LEG_COUNT       (LEGS),
      .SINE_TABLE_BITS (TABLE_BITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_leg       (req_leg),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_time_req  (req_time_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_leg_out   (rsp_leg_out),
      .rsp_foot_x    (rsp_foot_x),
      .rsp_foot_y    (rsp_foot_y),
      .rsp_foot_z    (rsp_foot_z),
      .rsp_not_ready (rsp_not_ready),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // signed Q15 sine at angle index idx (0..4N-1)
   function automatic longint signed_sine(input logic [63:0] idx);
      logic [1:0]  q;
      logic [63:0] r;
      longint      mag;
      q   = idx[TABLE_BITS+1:TABLE_BITS];
      r   = idx & (TABLE_N - 1);
      mag = q[0] ? longint'(sine_q15[TABLE_N - r]) : longint'(sine_q15[r]);
      return q[1] ? -mag : mag;
   endfunction

   function automatic longint scaled(input logic [AMP_W-1:0] amp, input longint s);
      logic [63:0] m;
      longint      v;
      m = (s < 0) ? 64'(-s) : 64'(s);
      v = longint'((64'(amp) * m + 64'd16384) >> 15);
      return (s < 0) ? -v : v;
   endfunction

   function automatic logic [OUT_W-1:0] clamp_foot(input longint v);
      if (v > FOOT_MAX)
         v = FOOT_MAX;
      if (v < FOOT_MIN)
         v = FOOT_MIN;
      return v[OUT_W-1:0];
   endfunction

   function automatic logic [AMP_W-1:0] rand_amp();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return AMP_W'($urandom);
      endcase
   endfunction

   task automatic predict_foot_targets(input logic [TIME_W-1:0] t);
      foot_target_type ft;
      logic [63:0]  c, t2, num, ph, idx;
      longint       fz;
      logic         ready;
      ready = &legs_loaded;
      c     = (period_ticks == 0) ? 64'd1 : 64'(period_ticks);
      for (int i = 0; i < LEGS; i++) begin
         ft.leg       = 3'(i);
         ft.not_ready = !ready;
         ft.last      = (i == LEGS - 1);
         ft.x         = '0;
         ft.y         = '0;
         ft.z         = '0;
         if (ready) begin
            t2 = 64'(t) << 1;
            if (tripod && i[0])
               t2 += c;
            num  = t2 % (c << 1);
            ph   = (num << 16) / (c << 1);
            idx  = (ph * (4 * TABLE_N)) >> 16;
            ft.x = clamp_foot(nrm_x[i]
                              - scaled(swing_um, signed_sine((idx + TABLE_N) & (4 * TABLE_N - 1))));
            ft.y = clamp_foot(nrm_y[i]);
            fz   = nrm_z[i];
            if (ph < 32768)
               fz += scaled(lift_um, signed_sine(idx));
            ft.z = clamp_foot(fz);
         end
         foot_targets_due.push_back(ft);
      end
   endtask

   task automatic send_command(input logic cmd, input logic [2:0] leg,
                               input logic signed [POS_W-1:0] px, py, pz,
                               input logic [TIME_W-1:0] t);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 12)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_leg      <= leg;
      req_pos_x    <= px;
      req_pos_y    <= py;
      req_pos_z    <= pz;
      req_time_req <= t;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_STEP) begin
         predict_foot_targets(t);
      end else if (leg < LEGS) begin
         nrm_x[leg]       = px;
         nrm_y[leg]       = py;
         nrm_z[leg]       = pz;
         legs_loaded[leg] = 1'b1;
      end
   endtask

   task automatic load_leg(input logic [2:0] leg, input logic signed [POS_W-1:0] px, py, pz);
      send_command(CMD_LOAD, leg, px, py, pz, $urandom);
   endtask

   task automatic step_at(input logic [TIME_W-1:0] t);
      send_command(CMD_STEP, 3'($urandom), POS_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom), t);
   endtask

   // only while idle: all results in, plus room for a trailing load
   task automatic write_reg(input logic [1:0] idx, input logic [CYCLE_W-1:0] data);
      req_valid <= 1'b0;
      while (foot_targets_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STEP_HEIGHT: lift_um      = data[AMP_W-1:0];
         CSR_STEP_LENGTH: swing_um     = data[AMP_W-1:0];
         CSR_CYCLE_TICKS: period_ticks = data;
         CSR_GAIT_MODE:   tripod       = data[0];
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers carry noise
   task automatic set_gait(input logic [AMP_W-1:0] h, l, input logic [CYCLE_W-1:0] c,
                           input logic m);
      write_reg(CSR_STEP_HEIGHT, {6'($urandom), h});
      write_reg(CSR_STEP_LENGTH, {6'($urandom), l});
      write_reg(CSR_CYCLE_TICKS, c);
      write_reg(CSR_GAIT_MODE, {23'($urandom), m});
   endtask

   task automatic report_mismatch(input string what, input int leg,
                                  input longint want_v, got_v);
      $display("mismatch: %s on leg %0d, expected %0d, got %0d", what, leg, want_v, got_v);
      errors++;
   endtask

   // steps before every leg is loaded, plus ignored loads
   task automatic test_not_loaded();
      step_at('0);
      step_at('1);
      load_leg(3'd0, -20'sd524288, 20'sd524287, 20'sd0);
      load_leg(3'd1, 20'sd524287, -20'sd524288, -20'sd1);
      load_leg(3'd6, 20'sd1, 20'sd1, 20'sd1);
      load_leg(3'd2, 20'sd0, 20'sd0, 20'sd0);
      load_leg(3'd3, -20'sd1, -20'sd1, 20'sd524287);
      load_leg(3'd4, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      load_leg(3'd7, -20'sd524288, -20'sd524288, -20'sd524288);
      step_at($urandom);
   endtask

   task automatic test_gait_extremes();
      load_leg(3'd5, 20'sd12345, -20'sd54321, -20'sd524288);
      step_at('0);
      set_gait('1, '1, CYCLE_RESET, 1'b1);
      step_at(32'd0);
      step_at(32'd250);
      step_at(32'd500);
      step_at(32'd750);
      step_at('1);
      load_leg(3'd0, -20'sd524288, -20'sd524288, -20'sd524288);
      load_leg(3'd1, 20'sd524287, 20'sd524287, 20'sd524287);
      set_gait('1, '1, '1, 1'b0);
      step_at('1);
      step_at(32'h003F_FFFF);
      // zero cycle acts as one: even legs get phase zero, odd legs in tripod mode do not
      set_gait('1, '1, '0, 1'b1);
      step_at($urandom);
      set_gait(18'd1, 18'd1, 24'd1, 1'b1);
      step_at(32'd1);
   endtask

   task automatic test_random_phases();
      int               idle_mix [4];
      int               stall_mix [4];
      logic [CYCLE_W-1:0] c;
      logic [TIME_W-1:0]  t;
      int               r;
      idle_mix  = '{0, 66, 0, 6};
      stall_mix = '{0, 0, 66, 6};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p];
         rsp_stall_pct = stall_mix[p];
         for (int n = 0; n < 105; n++) begin
            if (n % 35 == 0) begin
               case ($urandom_range(15))
                  0, 1:    c = 24'd1;
                  2, 3:    c = '1;
                  4:       c = '0;
                  5:       c = CYCLE_W'($urandom);
                  default: c = CYCLE_W'($urandom_range(1, 5000));
               endcase
               set_gait(rand_amp(), rand_amp(), c, 1'($urandom));
            end
            r = $urandom_range(99);
            if (r < 70) begin
               if ($urandom_range(3) == 0)
                  t = TIME_W'(period_ticks) * $urandom_range(0, 1000) + $urandom_range(0, 3);
               else
                  t = $urandom;
               step_at(t);
            end else if (r < 95) begin
               load_leg(3'($urandom_range(0, LEGS - 1)), POS_W'($urandom),
                        POS_W'($urandom), POS_W'($urandom));
            end else begin
               load_leg(3'($urandom_range(LEGS, 7)), POS_W'($urandom),
                        POS_W'($urandom), POS_W'($urandom));
            end
         end
      end
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go       = 1;
      repeat (12) step_at($urandom);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (foot_targets_due.size() == 0) begin
               report_mismatch("result with none due", rsp_leg_out, 0, 0);
            end else begin
               due = foot_targets_due.pop_front();
               if (rsp_leg_out !== due.leg)
                  report_mismatch("leg_out", due.leg, due.leg, rsp_leg_out);
               if (rsp_foot_x !== due.x)
                  report_mismatch("foot_x", due.leg, $signed(due.x), rsp_foot_x);
               if (rsp_foot_y !== due.y)
                  report_mismatch("foot_y", due.leg, $signed(due.y), rsp_foot_y);
               if (rsp_foot_z !== due.z)
                  report_mismatch("foot_z", due.leg, $signed(due.z), rsp_foot_z);
               if (rsp_not_ready !== due.not_ready)
                  report_mismatch("not_ready", due.leg, due.not_ready, rsp_not_ready);
               if (rsp_last !== due.last)
                  report_mismatch("last", due.leg, due.last, rsp_last);
            end
         end
         if (hold_go != 0) begin
            hold_left = HOLD_LEN;
            hold_go   = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] x, term;
      longint      sum;
      // quarter-wave table: Taylor series in Q30, rounded to Q15
      for (int k = 0; k <= TABLE_N; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / TABLE_N;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
               sum -= longint'(term);
            else
               sum += longint'(term);
         end
         if (sum < 0)
            sum = 0;
         sine_q15[k] = (64'(sum) + 64'd16384) >> 15;
      end
      legs_loaded  = '0;
      lift_um      = '0;
      swing_um     = '0;
      period_ticks = CYCLE_RESET;
      tripod       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_not_loaded();
      test_gait_extremes();
      test_random_phases();
      test_backpressure();

      req_valid <= 1'b0;
      while (foot_targets_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
